### rtl/core/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
   localparam int LEVELS      = $clog2(PATTERN_MAX + 1);

   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_STAR     = 8'h2A;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TARGET = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_ONE     = 2'd1,
      KIND_ANY     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OUTCOME_NO_MATCH = 2'd0,
      OUTCOME_MATCH    = 2'd1,
      OUTCOME_ERROR    = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [2:0]  len;
      logic [31:0] code;
   } symbol_type;

   // Clamp length to 1..4 and drop the bytes above it.
   function automatic symbol_type make_symbol(logic [31:0] code, logic [2:0] len);
      symbol_type sym;
      sym.len  = 3'd4;
      sym.code = code;
      case (len)
         3'd0, 3'd1: begin
            sym.len  = 3'd1;
            sym.code = {24'd0, code[7:0]};
         end
         3'd2: begin
            sym.len  = 3'd2;
            sym.code = {16'd0, code[15:0]};
         end
         3'd3: begin
            sym.len  = 3'd3;
            sym.code = {8'd0, code[23:0]};
         end
         default: begin
            sym.len  = 3'd4;
            sym.code = code;
         end
      endcase
      return sym;
   endfunction

endpackage

### rtl/core/wildcard_glob_matcher.sv
// Glob pattern matcher: pattern store, active-position set and result register.
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  request  | req_valid req_stall req_action req_char_code   | in
//           | req_char_len                                  |
//  response | rsp_valid rsp_stall rsp_outcome                | out
//
// One transaction per cycle unless stalled; answers pass input, then result register.
// Each character updates all 64 positions at once; star closure is a 7-level prefix OR.
// Synchronous reset empties the pattern and clears the active set; no clearing pass.
// A held response stalls the input only while an end-of-target transaction waits behind it.
module wildcard_glob_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_char_code,
   input  logic [2:0]  req_char_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_outcome
);

   localparam int N = wgm_pkg::PATTERN_MAX;

   // input register
   logic                    s1_valid_ff, s1_valid_in;
   wgm_pkg::action_type     s1_action_ff;
   logic [31:0]             s1_code_ff;
   logic [2:0]              s1_len_ff;

   // pattern store
   wgm_pkg::kind_type       kind_ff   [N];
   wgm_pkg::symbol_type     symbol_ff [N];
   logic                    store_we;
   wgm_pkg::kind_type       store_kind;

   logic [wgm_pkg::CNT_W-1:0] count_ff, count_in;
   logic                    overflow_ff, overflow_in;
   logic                    open_ff, open_in;
   logic [N:0]              active_ff, active_in;
   logic [N:0]              start_ff, start_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   wgm_pkg::outcome_type    rsp_outcome_ff, rsp_outcome_in;

   logic                    out_free;
   logic                    s1_fire;
   wgm_pkg::symbol_type     sym;
   logic                    sym_star;
   logic                    sym_one;
   logic [N:0]              le_count;
   logic [N:0]              base;
   logic [N:0]              stepped;
   logic [N:0]              prop;
   logic [N:0]              closed;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && ((s1_action_ff != wgm_pkg::ACT_END) || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   assign sym      = wgm_pkg::make_symbol(s1_code_ff, s1_len_ff);
   assign sym_star = (sym.len == 3'd1) && (sym.code[7:0] == wgm_pkg::CHAR_STAR);
   assign sym_one  = (sym.len == 3'd1) && (sym.code[7:0] == wgm_pkg::CHAR_QUESTION);
   assign base     = open_ff ? active_ff : start_ff;

   always_comb begin
      for (int i = 0; i <= N; i++) begin
         le_count[i] = (wgm_pkg::CNT_W'(i) <= count_ff);
      end
   end

   // one character step over every live position
   always_comb begin
      stepped = '0;
      prop    = '0;
      for (int i = 0; i < N; i++) begin
         prop[i+1] = le_count[i+1] && (kind_ff[i] == wgm_pkg::KIND_ANY);
         if (base[i] && le_count[i+1]) begin
            if (kind_ff[i] == wgm_pkg::KIND_ANY) begin
               stepped[i] = 1'b1;
            end else if ((kind_ff[i] == wgm_pkg::KIND_ONE) || (symbol_ff[i] == sym)) begin
               stepped[i+1] = 1'b1;
            end
         end
      end
   end

   // star closure as a parallel prefix: a set bit runs up through consecutive stars
   always_comb begin
      logic [N:0] a;
      logic [N:0] p;
      logic [N:0] a_nxt;
      logic [N:0] p_nxt;
      a = stepped;
      p = prop;
      for (int lvl = 0; lvl < wgm_pkg::LEVELS; lvl++) begin
         a_nxt = a;
         p_nxt = p;
         for (int i = 0; i <= N; i++) begin
            if (i >= (1 << lvl)) begin
               a_nxt[i] = a[i] | (p[i] & a[i - (1 << lvl)]);
               p_nxt[i] = p[i] & p[i - (1 << lvl)];
            end
         end
         a = a_nxt;
         p = p_nxt;
      end
      closed = a;
   end

   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      open_in        = open_ff;
      active_in      = active_ff;
      start_in       = start_ff;
      store_we       = 1'b0;
      store_kind     = wgm_pkg::KIND_LITERAL;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_valid_in   = rsp_stall ? rsp_valid_ff : 1'b0;
      if (sym_star) begin
         store_kind = wgm_pkg::KIND_ANY;
      end else if (sym_one) begin
         store_kind = wgm_pkg::KIND_ONE;
      end
      if (s1_fire) begin
         unique case (s1_action_ff)
            wgm_pkg::ACT_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
               open_in     = 1'b0;
               active_in   = '0;
               start_in    = {{N{1'b0}}, 1'b1};
            end
            wgm_pkg::ACT_APPEND: begin
               open_in = 1'b0;
               if (count_ff == wgm_pkg::CNT_W'(N)) begin
                  overflow_in = 1'b1;
               end else begin
                  store_we = 1'b1;
                  count_in = count_ff + wgm_pkg::CNT_W'(1);
                  // start set grows only when the new star follows a reachable position
                  if (sym_star && start_ff[count_ff]) begin
                     start_in[count_ff + wgm_pkg::CNT_W'(1)] = 1'b1;
                  end
               end
            end
            wgm_pkg::ACT_TARGET: begin
               open_in   = 1'b1;
               active_in = closed;
            end
            wgm_pkg::ACT_END: begin
               open_in      = 1'b0;
               active_in    = base;
               rsp_valid_in = 1'b1;
               if (overflow_ff) begin
                  rsp_outcome_in = wgm_pkg::OUTCOME_ERROR;
               end else if (base[count_ff]) begin
                  rsp_outcome_in = wgm_pkg::OUTCOME_MATCH;
               end else begin
                  rsp_outcome_in = wgm_pkg::OUTCOME_NO_MATCH;
               end
            end
            default: begin
               open_in = open_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         open_ff      <= 1'b0;
         active_ff    <= '0;
         start_ff     <= {{N{1'b0}}, 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         open_ff      <= open_in;
         active_ff    <= active_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_action_ff <= wgm_pkg::action_type'(req_action);
         s1_code_ff   <= req_char_code;
         s1_len_ff    <= req_char_len;
      end
      rsp_outcome_ff <= rsp_outcome_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         kind_ff[count_ff[wgm_pkg::IDX_W-1:0]]   <= store_kind;
         symbol_ff[count_ff[wgm_pkg::IDX_W-1:0]] <= sym;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wgm_pkg::CNT_W'(N))
      else $error("pattern count beyond store size");

   a_active_live: assert property (@(posedge clock) disable iff (reset)
      ((active_ff & ~le_count) == '0) && ((start_ff & ~le_count) == '0))
      else $error("active position beyond pattern end");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && (s1_action_ff == wgm_pkg::ACT_END) && rsp_valid_ff))
      else $error("input stalled without a blocked end of target");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_action_ff == wgm_pkg::ACT_END)) |=> (!open_ff && rsp_valid_ff))
      else $error("end of target left target open or gave no response");

   a_error_outcome: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_action_ff == wgm_pkg::ACT_END) && overflow_ff)
         |=> (rsp_outcome_ff == wgm_pkg::OUTCOME_ERROR))
      else $error("overflowed pattern did not answer error");

endmodule
